// ===== rtl/rmq_pkg.sv =====
// shared constants and transfer types for the range mex query core
package rmq_pkg;

  localparam int MAX_LEN   = 1024;
  localparam int MAP_DEPTH = MAX_LEN + 1;
  localparam int IDX_W     = $clog2(MAX_LEN);
  localparam int CNT_W     = $clog2(MAX_LEN + 1);
  localparam int VAL_W     = $clog2(MAX_LEN + 2);
  localparam int MAP_W     = $clog2(MAP_DEPTH);
  localparam int ELEM_W    = 32;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [ELEM_W-1:0] element_value;
    logic [9:0]        query_left;
    logic [9:0]        query_right;
  } rmq_in_t;

  typedef struct packed {
    logic [10:0] mex_value;
    logic        range_error;
  } rmq_out_t;

endpackage

// ===== rtl/range_mex_query_core.sv =====
// range mex query core: element store, presence map scan and mex search
//
// usage
//   input channel (in_valid / in_stall / in_data): one transfer per item.
//   a load appends a value (values above MAX_LEN stored as absent); loads
//   beyond MAX_LEN elements are dropped. a query names [left, right] and
//   returns one result transfer on the output channel.
//   output channel (out_valid / out_stall / out_data): mex_value and
//   range_error, in query arrival order.
// sequencing and throughput
//   a load is written into the element store without leaving the idle state. a
//   query with a bad range goes straight to the emit state. a valid query steps
//   through scan, scan wait, search, search drain and emit: one element store
//   read per cycle over the range, then one presence map read and clear per
//   cycle over all MAX_LEN + 1 entries. one item is worked on at a time.
// reset
//   loaded count is zeroed, then the presence map is cleared in a pass over all
//   MAX_LEN + 1 entries during which in_stall stays high.
// stall
//   a finished result waits in a pending register while out_stall is high;
//   no further input is taken until it has moved to the output register.
module range_mex_query_core
  import rmq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  rmq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output rmq_out_t out_data
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CLR    = 7'b0000010,
    ST_SCAN   = 7'b0000100,
    ST_SWAIT  = 7'b0001000,
    ST_SEARCH = 7'b0010000,
    ST_SDRAIN = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [VAL_W-1:0] elem_mem [MAX_LEN];
  logic             pmap_mem [MAP_DEPTH];

  logic [CNT_W-1:0] loaded_count_r;
  logic [IDX_W-1:0] scan_idx_r;
  logic [IDX_W-1:0] scan_end_r;
  logic [MAP_W-1:0] sidx_r;

  logic [VAL_W-1:0] elem_rd_r;
  logic             elem_vld_r;
  logic             pmap_rd_r;
  logic             pmap_vld_r;
  logic [MAP_W-1:0] pmap_addr_q_r;

  logic             found_r;
  rmq_out_t         res_r;
  logic             out_valid_r;
  rmq_out_t         out_data_r;

  logic             in_xfer;
  logic             q_err;
  logic             emit_go;
  logic             sweep_last;
  logic             pm_we;
  logic [MAP_W-1:0] pm_wa;
  logic             pm_wd;
  logic [VAL_W-1:0] load_val;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign q_err = (in_data.query_left > in_data.query_right) ||
                 ({1'b0, in_data.query_right} >= loaded_count_r);
  assign emit_go    = !out_valid_r || !out_stall;
  assign sweep_last = (sidx_r == MAP_W'(MAX_LEN));
  assign load_val   = (in_data.element_value > ELEM_W'(MAX_LEN)) ?
                      VAL_W'(MAX_LEN + 1) : in_data.element_value[VAL_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_data.opcode == OP_QUERY) begin
          state_nxt = q_err ? ST_EMIT : ST_SCAN;
        end
      end
      ST_CLR: begin
        if (sweep_last) state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_idx_r == scan_end_r) state_nxt = ST_SWAIT;
      end
      ST_SWAIT:  state_nxt = ST_SEARCH;
      ST_SEARCH: begin
        if (sweep_last) state_nxt = ST_SDRAIN;
      end
      ST_SDRAIN: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (emit_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // presence map write port: clear sweep or set from scanned element
  always_comb begin
    pm_we = 1'b0;
    pm_wa = sidx_r;
    pm_wd = 1'b0;
    priority if (state_r == ST_CLR || state_r == ST_SEARCH) begin
      pm_we = 1'b1;
    end else if (elem_vld_r && elem_rd_r <= VAL_W'(MAX_LEN)) begin
      pm_we = 1'b1;
      pm_wa = MAP_W'(elem_rd_r);
      pm_wd = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pm_we) pmap_mem[pm_wa] <= pm_wd;
    pmap_rd_r <= pmap_mem[sidx_r];
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_data.opcode == OP_LOAD && loaded_count_r < CNT_W'(MAX_LEN)) begin
      elem_mem[loaded_count_r[IDX_W-1:0]] <= load_val;
    end
    elem_rd_r <= elem_mem[scan_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLR;
      loaded_count_r <= '0;
      sidx_r         <= '0;
      elem_vld_r     <= 1'b0;
      pmap_vld_r     <= 1'b0;
      found_r        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      elem_vld_r <= (state_r == ST_SCAN);
      pmap_vld_r <= (state_r == ST_SEARCH);

      if (in_xfer && in_data.opcode == OP_LOAD && loaded_count_r < CNT_W'(MAX_LEN)) begin
        loaded_count_r <= loaded_count_r + CNT_W'(1);
      end

      if (state_r == ST_CLR || state_r == ST_SEARCH) begin
        sidx_r <= sweep_last ? '0 : sidx_r + MAP_W'(1);
      end

      if (state_r == ST_SCAN) begin
        scan_idx_r <= scan_idx_r + IDX_W'(1);
      end else if (in_xfer && in_data.opcode == OP_QUERY) begin
        scan_idx_r <= in_data.query_left;
      end

      if (in_xfer && in_data.opcode == OP_QUERY) begin
        found_r <= 1'b0;
        if (q_err) begin
          res_r.mex_value   <= '0;
          res_r.range_error <= 1'b1;
        end else begin
          res_r.mex_value   <= '0;
          res_r.range_error <= 1'b0;
        end
      end else if (pmap_vld_r && !found_r && !pmap_rd_r) begin
        found_r         <= 1'b1;
        res_r.mex_value <= 11'(pmap_addr_q_r);
      end

      if (state_r == ST_EMIT && emit_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pmap_addr_q_r <= sidx_r;
    if (state_r == ST_EMIT && emit_go) begin
      out_data_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_data.opcode == OP_QUERY) begin
      scan_end_r <= in_data.query_right;
    end
  end

endmodule

// ===== verif/range_mex_query_checker.sv =====
// checker for the range mex query core: predicts each query result and compares transfers
`timescale 1ns / 100ps

module range_mex_query_checker
  import rmq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  rmq_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  rmq_out_t out_data,
  output int       fail_cnt,
  output int       pending_cnt
);

  logic [VAL_W-1:0] elem_mem [MAX_LEN];
  logic [CNT_W-1:0] loaded_cnt;
  rmq_out_t         mex_expected_q[$];
  int               mismatch_cnt;

  assign fail_cnt = mismatch_cnt;

  initial begin
    mismatch_cnt = 0;
    pending_cnt  = 0;
    loaded_cnt   = '0;
  end

  function automatic rmq_out_t predict_range_mex(input logic [9:0] lo, input logic [9:0] hi);
    rmq_out_t         res;
    logic [MAX_LEN:0] seen_map;
    int               m;
    res      = '0;
    seen_map = '0;
    m        = 0;
    if (lo > hi || {1'b0, hi} >= loaded_cnt) begin
      res.range_error = 1'b1;
      return res;
    end
    for (int i = lo; i <= hi; i++) begin
      if (elem_mem[i] <= MAX_LEN) seen_map[elem_mem[i]] = 1'b1;
    end
    while (m <= MAX_LEN && seen_map[m]) m++;
    res.mex_value = m[10:0];
    return res;
  endfunction

  always @(posedge clk) begin
    rmq_out_t exp_res;
    if (!rst_n) begin
      mex_expected_q.delete();
      loaded_cnt  = '0;
      pending_cnt <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (mex_expected_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: result with no query waiting: mex %0d err %0b",
                     $realtime, out_data.mex_value, out_data.range_error);
        end else begin
          exp_res = mex_expected_q.pop_front();
          if (out_data.mex_value !== exp_res.mex_value ||
              out_data.range_error !== exp_res.range_error) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("%0t: mismatch: expected mex %0d err %0b, got mex %0d err %0b",
                       $realtime, exp_res.mex_value, exp_res.range_error,
                       out_data.mex_value, out_data.range_error);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.opcode == OP_QUERY) begin
          mex_expected_q.insert(mex_expected_q.size(),
                                predict_range_mex(in_data.query_left, in_data.query_right));
        end else if (loaded_cnt < MAX_LEN) begin
          // values above the store size mean absent
          if (in_data.element_value > MAX_LEN)
            elem_mem[loaded_cnt[IDX_W-1:0]] = VAL_W'(MAX_LEN + 1);
          else
            elem_mem[loaded_cnt[IDX_W-1:0]] = in_data.element_value[VAL_W-1:0];
          loaded_cnt = loaded_cnt + 1'b1;
        end
      end
      pending_cnt <= mex_expected_q.size();
    end
  end

endmodule

// ===== verif/range_mex_query_core_tb.sv =====
// testbench top for the range mex query core: stimulus, receiver stalls and verdict
`timescale 1ns / 100ps

module range_mex_query_core_tb;
  import rmq_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  rmq_in_t  in_data;
  logic     out_valid;
  logic     out_stall = 1'b0;
  rmq_out_t out_data;
  int       fail_cnt;
  int       pending_cnt;

  int       burst_left;
  int       stored_cnt;
  int       stall_mode;
  int       stall_left;

  range_mex_query_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  range_mex_query_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .fail_cnt    (fail_cnt),
    .pending_cnt (pending_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("range_mex_query_core verification failed");
    $finish;
  end

  // receiver stall pattern: free running, light random, heavy random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_mode <= 0;
      stall_left <= 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_left <= $urandom_range(20, 400);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: begin
          out_stall <= 1'b0;
        end
        1: begin
          out_stall <= ($urandom_range(0, 99) < 35);
        end
        default: begin
          out_stall <= ($urandom_range(0, 9) < 8);
        end
      endcase
    end
  end

  task automatic send_item(input rmq_in_t item);
    int gap;
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
  endtask

  task automatic do_load(input logic [31:0] v);
    rmq_in_t item;
    item.opcode        = OP_LOAD;
    item.element_value = v;
    item.query_left    = 10'($urandom());
    item.query_right   = 10'($urandom());
    send_item(item);
    if (stored_cnt < MAX_LEN) begin
      stored_cnt++;
    end
  endtask

  task automatic do_query(input int lo, input int hi);
    rmq_in_t item;
    item.opcode        = OP_QUERY;
    item.element_value = $urandom();
    item.query_left    = lo[9:0];
    item.query_right   = hi[9:0];
    send_item(item);
  endtask

  task automatic random_load();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 7);
      4, 5:       v = $urandom_range(0, stored_cnt + 4);
      6:          v = $urandom_range(0, MAX_LEN + 1);
      7:          v = MAX_LEN + $urandom_range(0, 3);
      default:    v = $urandom();
    endcase
    do_load(v);
  endtask

  task automatic random_query(input int span_max);
    int hi;
    int lo;
    int span;
    if (stored_cnt > 0 && $urandom_range(0, 4) != 0) begin
      hi   = $urandom_range(0, stored_cnt - 1);
      span = ($urandom_range(0, 3) != 0) ? $urandom_range(0, span_max) : hi;
      if (span > hi) span = hi;
      lo   = hi - span;
    end else begin
      lo = $urandom_range(0, 1023);
      hi = $urandom_range(0, 1023);
    end
    do_query(lo, hi);
  endtask

  initial begin
    in_valid   <= 1'b0;
    in_data    <= '0;
    rst_n      <= 1'b0;
    burst_left = $urandom_range(1, 8);
    stored_cnt = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, small store
    do_query(0, 0);
    do_load(32'd0);
    do_load(32'd1);
    do_load(32'hFFFF_FFFF);
    do_load(32'd1024);
    do_load(32'd1025);
    do_load(32'd3);
    do_load(32'd2);
    do_query(0, 6);
    do_query(0, 0);
    do_query(1, 1);
    do_query(2, 4);
    do_query(3, 3);
    do_query(0, 1);
    do_query(5, 6);
    do_query(6, 5);
    do_query(0, 7);
    do_query(1023, 1023);
    do_query(0, 1023);
    do_query(1023, 0);

    // random mix on a growing store
    repeat (200) begin
      if ($urandom_range(0, 99) < 45) random_load();
      else random_query(15);
    end

    repeat (60) begin
      if ($urandom_range(0, 99) < 15) random_load();
      else random_query(1023);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (2 * MAX_LEN + 16) @(posedge clk);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("range_mex_query_core verification clean");
    end else begin
      $display("range_mex_query_core verification failed");
    end
    $finish;
  end

endmodule
